@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, switched off while reset is held
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/frc_pkg.sv @@
// ----------------------------------------------------------------------------
// frc_pkg
// Types and fixed constants of the FIFO replacement cache.
// ----------------------------------------------------------------------------
package frc_pkg;

    // Capacity register and entry count field widths
    localparam int CAP_W   = 4;
    localparam int COUNT_W = 4;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    // Operation carried on the input tuser
    typedef enum logic [0:0] {
        ACT_PUT = 1'b0,
        ACT_GET = 1'b1
    } action_t;

    // Command from the pipeline control to the store
    typedef struct packed {
        logic    clear;
        logic    fire;
        action_t action;
    } frc_cmd_t;

    // Result flags from the store
    typedef struct packed {
        logic hit;
        logic evicted;
    } frc_flags_t;

endpackage

@@ rtl/frc_store.sv @@
// ----------------------------------------------------------------------------
// frc_store
// Entry store with parallel key match, FIFO ring pointers and update logic.
// ----------------------------------------------------------------------------
module frc_store #(
    parameter int DEPTH       = 8,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  frc_pkg::frc_cmd_t           cmd,
    input  logic [KEY_WIDTH-1:0]        key,
    input  logic [VALUE_WIDTH-1:0]      value,
    input  logic [frc_pkg::CAP_W-1:0]   capacity,
    output frc_pkg::frc_flags_t         flags,
    output logic [VALUE_WIDTH-1:0]      read_value,
    output logic [KEY_WIDTH-1:0]        evicted_key,
    output logic [frc_pkg::COUNT_W-1:0] entry_count
);
    import frc_pkg::*;

    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
    localparam int SUM_W  = FILL_W + 1;

    logic [KEY_WIDTH-1:0]   key_store_reg   [DEPTH];
    logic [VALUE_WIDTH-1:0] value_store_reg [DEPTH];
    logic [DEPTH-1:0]       valid_reg;
    logic [DEPTH-1:0]       valid_next;
    logic [SLOT_W-1:0]      oldest_reg;
    logic [SLOT_W-1:0]      oldest_next;
    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      fill_next;

    logic [DEPTH-1:0]       match;
    logic                   hit;
    logic [VALUE_WIDTH-1:0] hit_value;
    logic [CMP_W-1:0]       cap_ext;
    logic [CMP_W-1:0]       eff_cap;
    logic                   is_put;
    logic                   do_update;
    logic                   do_insert;
    logic                   do_evict;
    logic [SUM_W-1:0]       pos_sum;
    logic [SLOT_W-1:0]      ins_slot;

    // Parallel key compare against every valid entry; keys are unique
    always_comb begin
        match     = '0;
        hit_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            match[i] = valid_reg[i] && (key_store_reg[i] == key);
            if (match[i]) begin
                hit_value = hit_value | value_store_reg[i];
            end
        end
    end
    assign hit = |match;

    // Effective capacity: zero acts as one, clipped to the store depth
    always_comb begin
        cap_ext = CMP_W'(capacity);
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(DEPTH)) begin
            eff_cap = CMP_W'(DEPTH);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign is_put    = cmd.fire && (cmd.action == ACT_PUT);
    assign do_update = is_put && hit;
    assign do_insert = is_put && !hit;
    assign do_evict  = do_insert && (CMP_W'(fill_reg) >= eff_cap);

    // Insert slot: oldest + fill wraps the ring (covers the evicting case too)
    always_comb begin
        pos_sum = SUM_W'(oldest_reg) + SUM_W'(fill_reg);
        if (pos_sum >= SUM_W'(DEPTH)) begin
            ins_slot = SLOT_W'(pos_sum - SUM_W'(DEPTH));
        end else begin
            ins_slot = SLOT_W'(pos_sum);
        end
    end

    // Ring pointer, fill count and valid bit next values
    always_comb begin
        oldest_next = oldest_reg;
        fill_next   = fill_reg;
        valid_next  = valid_reg;
        if (do_evict) begin
            oldest_next = (oldest_reg == SLOT_W'(DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
            valid_next[oldest_reg] = 1'b0;
        end else if (do_insert) begin
            fill_next = fill_reg + 1'b1;
        end
        if (do_insert) begin
            valid_next[ins_slot] = 1'b1;
        end
    end

    // Control state: valid bits and ring pointers
    always_ff @(posedge clk) begin
        if (!rst_n || cmd.clear) begin
            valid_reg  <= '0;
            oldest_reg <= '0;
            fill_reg   <= '0;
        end else begin
            oldest_reg <= oldest_next;
            fill_reg   <= fill_next;
            valid_reg  <= valid_next;
        end
    end

    // Key and value storage, no reset
    always_ff @(posedge clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (do_update && match[i]) begin
                value_store_reg[i] <= value;
            end
        end
        if (do_insert) begin
            key_store_reg[ins_slot]   <= key;
            value_store_reg[ins_slot] <= value;
        end
    end

    // Result fields
    assign flags.hit     = hit;
    assign flags.evicted = do_evict;
    assign read_value    = (cmd.action == ACT_GET && hit) ? hit_value : '0;
    assign evicted_key   = do_evict ? key_store_reg[oldest_reg] : '0;
    assign entry_count   = COUNT_W'(fill_next);

endmodule

@@ rtl/fifo_replacement_cache_core.sv @@
// ----------------------------------------------------------------------------
// fifo_replacement_cache_core
// Fully associative key/value cache with first-in-first-out replacement.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one put or get per transfer: s_tuser is the action,
//   s_tdata the key and value. m_ channel returns one result per transfer:
//   hit and eviction flags on m_tuser, read value, evicted key and entry
//   count on m_tdata.
//   cfg_we with cfg_wdata writes the capacity and empties the cache; write
//   it only while no transfer is in flight.
//   Path: an accepted item is held in the input register; its result is
//   registered in the result register and then offered on m_.
//   Throughput: one item per cycle while m_tready is high. Key compare,
//   ring update and result forming are combinational between the input
//   and result registers, and back-to-back items see each other's updates.
//   Stall: while m_tready is low the result holds; the input register
//   takes one more item and then s_tready drops until the result leaves.
//   Reset: synchronous, active low; empties the cache, capacity returns to
//   eight and both registers are emptied.
// ----------------------------------------------------------------------------
module fifo_replacement_cache_core #(
    parameter int DEPTH       = 8,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    localparam int IN_W  = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((VALUE_WIDTH + KEY_WIDTH + frc_pkg::COUNT_W + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // capacity register
    input  logic                       cfg_we,
    input  logic [frc_pkg::CAP_W-1:0]  cfg_wdata,
    // input items
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [IN_W-1:0]            s_tdata,   // key, value, zero pad
    input  frc_pkg::action_t           s_tuser,   // action
    // results
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_W-1:0]           m_tdata,   // read_value, evicted_key, entry_count, pad
    output logic [1:0]                 m_tuser    // hit, evicted
);
    import frc_pkg::*;

    localparam int PAD_W = OUT_W - VALUE_WIDTH - KEY_WIDTH - COUNT_W;

    logic                   in_vld_reg;
    action_t                in_act_reg;
    logic [KEY_WIDTH-1:0]   in_key_reg;
    logic [VALUE_WIDTH-1:0] in_val_reg;
    logic [CAP_W-1:0]       capacity_reg;

    logic                   out_vld_reg;
    logic [1:0]             out_user_reg;
    logic [OUT_W-1:0]       out_data_reg;

    logic                   fire;
    frc_cmd_t               cmd;
    frc_flags_t             flags;
    logic [VALUE_WIDTH-1:0] read_value;
    logic [KEY_WIDTH-1:0]   evicted_key;
    logic [COUNT_W-1:0]     entry_count;

    // Process the held item whenever the result register is free or draining
    assign fire     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_we) begin
            capacity_reg <= cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_act_reg <= s_tuser;
            in_key_reg <= s_tdata[KEY_WIDTH-1:0];
            in_val_reg <= s_tdata[KEY_WIDTH +: VALUE_WIDTH];
        end
    end

    assign cmd.clear  = cfg_we;
    assign cmd.fire   = fire;
    assign cmd.action = in_act_reg;

    frc_store #(
        .DEPTH       (DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .clk         (aclk),
        .rst_n       (aresetn),
        .cmd         (cmd),
        .key         (in_key_reg),
        .value       (in_val_reg),
        .capacity    (capacity_reg),
        .flags       (flags),
        .read_value  (read_value),
        .evicted_key (evicted_key),
        .entry_count (entry_count)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (fire) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_user_reg <= {flags.evicted, flags.hit};
            out_data_reg <= {PAD_W'(0), entry_count, evicted_key, read_value};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

@@ rtl/frc_checker.sv @@
// ----------------------------------------------------------------------------
// frc_checker
// Port-level checks on the FIFO replacement cache result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frc_checker #(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int OUT_W       = 72
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic [1:0]       m_tuser
);
    import frc_pkg::*;

    logic                   res_hit;
    logic                   res_evicted;
    logic [VALUE_WIDTH-1:0] res_read;
    logic [KEY_WIDTH-1:0]   res_evk;

    assign res_hit     = m_tuser[0];
    assign res_evicted = m_tuser[1];
    assign res_read    = m_tdata[VALUE_WIDTH-1:0];
    assign res_evk     = m_tdata[VALUE_WIDTH +: KEY_WIDTH];

    // A stalled result holds
    `ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // An eviction only follows an insert of a key that missed
    `ASSERT_IMP(a_evict_miss, aclk, aresetn, m_tvalid && res_evicted, !res_hit)
    // Evicted key reads zero when nothing was evicted
    `ASSERT_IMP(a_evk_zero, aclk, aresetn, m_tvalid && !res_evicted, res_evk == '0)
    // A miss never returns a value
    `ASSERT_IMP(a_miss_zero, aclk, aresetn, m_tvalid && !res_hit, res_read == '0)

endmodule

bind fifo_replacement_cache_core frc_checker #(
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .OUT_W       (OUT_W)
) u_frc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
